// ===== sv/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg - shared types, constants and microcode for the PID controller
// Widths, register indexes, result codes, control word layout, the microcode
// program and the saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  // Datapath width of integral, accumulator and previous unclamped output
  localparam int DATA_WIDTH = 32;
  localparam int DW         = DATA_WIDTH;
  // Fixed field widths
  localparam int ERR_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int FRAC_W     = 16;
  // Simpson integrand eb + 4*el + e is kept exact
  localparam int SUM_W      = ERR_W + 3;
  localparam int MAXW       = (DW > ERR_W) ? DW : ERR_W;
  localparam int ADD_W      = MAXW + 1;
  localparam int MA_W       = (SUM_W > DW) ? SUM_W : DW;
  localparam int P_W        = MA_W + GAIN_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 4'd0,
    REG_INT_GAIN_SIM = 4'd1,
    REG_INT_GAIN_TRP = 4'd2,
    REG_AW_GAIN_SIM  = 4'd3,
    REG_AW_GAIN_TRP  = 4'd4,
    REG_DERIV_GAIN   = 4'd5,
    REG_OUT_HIGH     = 4'd6,
    REG_OUT_LOW      = 4'd7
  } reg_idx_t;

  // limit_hit codes
  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_HIGH = 2'd1,
    HIT_LOW  = 2'd2
  } hit_t;

  // Microcode fields
  typedef enum logic [1:0] {
    MS_ISUM = 2'd0,
    MS_TMP  = 2'd1,
    MS_DIFF = 2'd2,
    MS_ACC  = 2'd3
  } mul_src_t;

  typedef enum logic [1:0] {
    G_INT   = 2'd0,
    G_AW    = 2'd1,
    G_DERIV = 2'd2,
    G_PROP  = 2'd3
  } gain_sel_t;

  typedef enum logic [2:0] {
    AO_HOLD      = 3'd0,
    AO_LOAD_Q    = 3'd1,
    AO_ADD_Q     = 3'd2,
    AO_ADD_INTEG = 3'd3,
    AO_ADD_ERR   = 3'd4
  } acc_op_t;

  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_WAIT_IN  = 2'd1,
    J_WAIT_OUT = 2'd2
  } jmp_t;

  typedef struct packed {
    logic      mul_en;
    mul_src_t  mul_src;
    gain_sel_t gain;
    acc_op_t   acc_op;
    logic      tmp_en;
    logic      integ_en;
    logic      commit;
    jmp_t      jmp;
  } ucode_t;

  // Control from sequencer to datapath, qualified by handshakes
  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    mul_src_t  mul_src;
    gain_sel_t gain;
    acc_op_t   acc_op;
    logic      tmp_en;
    logic      integ_en;
    logic      commit;
  } ctl_t;

  localparam int STEPS  = 10;
  localparam int STEP_W = $clog2(STEPS);

  localparam ucode_t UC_NOP = '{
    mul_en: 1'b0, mul_src: MS_ISUM, gain: G_INT, acc_op: AO_HOLD,
    tmp_en: 1'b0, integ_en: 1'b0, commit: 1'b0, jmp: J_NEXT
  };

  // Program: one control word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      4'd0: begin                    // wait for a sample
        uc.jmp = J_WAIT_IN;
      end
      4'd1: begin                    // anti-windup excess; integrand * Ki
        uc.tmp_en  = 1'b1;
        uc.mul_en  = 1'b1;
        uc.mul_src = MS_ISUM;
        uc.gain    = G_INT;
      end
      4'd2: begin                    // excess * Kaw
        uc.mul_en  = 1'b1;
        uc.mul_src = MS_TMP;
        uc.gain    = G_AW;
        uc.acc_op  = AO_LOAD_Q;
      end
      4'd3: begin                    // (e - eb) * Kd
        uc.mul_en  = 1'b1;
        uc.mul_src = MS_DIFF;
        uc.gain    = G_DERIV;
        uc.acc_op  = AO_ADD_Q;
      end
      4'd4: begin
        uc.acc_op = AO_ADD_INTEG;
      end
      4'd5: begin                    // acc now holds I; add D
        uc.integ_en = 1'b1;
        uc.acc_op   = AO_ADD_Q;
      end
      4'd6: begin
        uc.acc_op = AO_ADD_ERR;
      end
      4'd7: begin                    // (I + D + e) * Kp
        uc.mul_en  = 1'b1;
        uc.mul_src = MS_ACC;
        uc.gain    = G_PROP;
      end
      4'd8: begin
        uc.acc_op = AO_LOAD_Q;
      end
      4'd9: begin                    // clamp, update state, emit
        uc.commit = 1'b1;
        uc.jmp    = J_WAIT_OUT;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
    return uc;
  endfunction

  // Saturate a sum of two sign-extended operands to DW bits
  function automatic logic signed [DW-1:0] sat_add(
    input logic signed [ADD_W-1:0] a,
    input logic signed [ADD_W-1:0] b
  );
    logic signed [ADD_W:0] s;
    logic signed [ADD_W:0] hi_lim;
    logic signed [ADD_W:0] lo_lim;
    s      = (ADD_W+1)'(a) + (ADD_W+1)'(b);
    hi_lim = {{(ADD_W+2-DW){1'b0}}, {(DW-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (s > hi_lim) begin
      return hi_lim[DW-1:0];
    end else if (s < lo_lim) begin
      return lo_lim[DW-1:0];
    end
    return s[DW-1:0];
  endfunction

  // Q16.16 product: floor shift then saturate to DW bits
  function automatic logic signed [DW-1:0] sat_prod(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] sh;
    logic signed [P_W-1:0] hi_lim;
    logic signed [P_W-1:0] lo_lim;
    sh     = p >>> FRAC_W;
    hi_lim = {{(P_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (sh > hi_lim) begin
      return hi_lim[DW-1:0];
    end else if (sh < lo_lim) begin
      return lo_lim[DW-1:0];
    end
    return sh[DW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/pid_simpson_trapezoid_antiwindup_top.sv =====
// ----------------------------------------------------------------------------
// pid_simpson_trapezoid_antiwindup_top - Q16.16 PID controller
// Alternating trapezoid/Simpson integral with back-calculation anti-windup,
// central-difference derivative, Kp scaling and output clamp.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  in_error_in  (s32 Q16.16)
//  out_     output     out_valid/out_stall  out_drive (s32), out_limit_hit (2b)
//  cfg_     input      cfg_we               cfg_index (4b), cfg_wdata (32b)
//
//  A transaction is taken when valid is high and stall is low.
//  The step counter of the sequencer walks a ten-word
//  program that shares one multiplier across the four gain products.
//  in_stall is low only on the idle step; the next sample waits there.
//  A finished result sits in the output register; a new sample may be taken
//  meanwhile, and its last step holds while out_stall keeps the register full.
//  Synchronous active-low reset clears state, gains and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_simpson_trapezoid_antiwindup_top
  import pst_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ERR_W-1:0] in_error_in,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ERR_W-1:0]      out_drive,
  output logic [1:0]                   out_limit_hit,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata
);

  ctl_t ctl;       // per-step control word, handshake qualified
  logic out_busy;  // output register full and held

  // Sequencer: step counter plus program ROM
  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  // Datapath: config, state, multiplier, accumulator, clamp, output stage
  pst_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_error_in   (in_error_in),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_stall     (out_stall),
    .out_busy      (out_busy),
    .out_valid     (out_valid),
    .out_drive     (out_drive),
    .out_limit_hit (out_limit_hit)
  );

endmodule

`default_nettype wire

// ===== sv/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl - microcode sequencer
// Step counter, program ROM lookup and conditional jumps on the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_busy,
  output ctl_t      ctl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uc;
  logic              take;

  assign uc       = ucode_rom(step_r);
  assign in_stall = (uc.jmp != J_WAIT_IN);
  assign take     = in_valid && (uc.jmp == J_WAIT_IN);

  always_comb begin
    step_nxt = step_r;
    case (uc.jmp)
      J_WAIT_IN: begin
        if (take) begin
          step_nxt = step_r + 1'b1;
        end
      end
      J_WAIT_OUT: begin
        if (!out_busy) begin
          step_nxt = '0;
        end
      end
      J_NEXT: begin
        step_nxt = step_r + 1'b1;
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctl.load_in  = take;
    ctl.mul_en   = uc.mul_en;
    ctl.mul_src  = uc.mul_src;
    ctl.gain     = uc.gain;
    ctl.acc_op   = uc.acc_op;
    ctl.tmp_en   = uc.tmp_en;
    ctl.integ_en = uc.integ_en;
    ctl.commit   = uc.commit && !out_busy;
  end

endmodule

`default_nettype wire

// ===== sv/pst_dpath.sv =====
// ----------------------------------------------------------------------------
// pst_dpath - PID datapath
// Config registers, controller state, shared multiplier, saturating
// accumulator, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_dpath
  import pst_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctl_t                    ctl,
  input  wire logic signed [ERR_W-1:0] in_error_in,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  input  wire logic                    out_stall,
  output logic                         out_busy,
  output logic                         out_valid,
  output logic signed [ERR_W-1:0]      out_drive,
  output logic [1:0]                   out_limit_hit
);

  // configuration
  logic signed [GAIN_W-1:0] kp_r, kis_r, kit_r, kas_r, kat_r, kd_r, hi_r, lo_r;

  // controller state
  logic signed [ERR_W-1:0] el_r, eb_r;
  logic signed [DW-1:0]    il_r, ib_r, ul_r;
  logic                    phase_r;

  // working registers
  logic signed [ERR_W-1:0] e_r;
  logic signed [DW-1:0]    tmp_r, integ_r, acc_r, acc_nxt;
  logic signed [P_W-1:0]   prod_r;

  // output register
  logic                    out_valid_r;
  logic signed [ERR_W-1:0] out_drive_r;
  hit_t                    out_hit_r;

  logic signed [SUM_W-1:0]  isum, dsum;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [GAIN_W-1:0] mul_g;
  logic signed [DW-1:0]     q, tmp_nxt;
  logic signed [ADD_W-1:0]  ul_x, hi_x, lo_x;
  logic signed [ERR_W-1:0]  drive_nxt;
  hit_t                     hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      kis_r <= '0;
      kit_r <= '0;
      kas_r <= '0;
      kat_r <= '0;
      kd_r  <= '0;
      hi_r  <= {1'b0, {(GAIN_W-1){1'b1}}};
      lo_r  <= {1'b1, {(GAIN_W-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:    kp_r  <= cfg_wdata;
        REG_INT_GAIN_SIM: kis_r <= cfg_wdata;
        REG_INT_GAIN_TRP: kit_r <= cfg_wdata;
        REG_AW_GAIN_SIM:  kas_r <= cfg_wdata;
        REG_AW_GAIN_TRP:  kat_r <= cfg_wdata;
        REG_DERIV_GAIN:   kd_r  <= cfg_wdata;
        REG_OUT_HIGH:     hi_r  <= cfg_wdata;
        REG_OUT_LOW:      lo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // exact error sums
  always_comb begin
    if (phase_r) begin
      isum = SUM_W'(eb_r) + (SUM_W'(el_r) <<< 2) + SUM_W'(e_r);
    end else begin
      isum = SUM_W'(el_r) + SUM_W'(e_r);
    end
    dsum = SUM_W'(e_r) - SUM_W'(eb_r);
  end

  always_comb begin
    case (ctl.mul_src)
      MS_ISUM: mul_a = MA_W'(isum);
      MS_TMP:  mul_a = MA_W'(tmp_r);
      MS_DIFF: mul_a = MA_W'(dsum);
      MS_ACC:  mul_a = MA_W'(acc_r);
      default: mul_a = '0;
    endcase
    case (ctl.gain)
      G_INT:   mul_g = phase_r ? kis_r : kit_r;
      G_AW:    mul_g = phase_r ? kas_r : kat_r;
      G_DERIV: mul_g = kd_r;
      G_PROP:  mul_g = kp_r;
      default: mul_g = '0;
    endcase
  end

  assign q = sat_prod(prod_r);

  // anti-windup excess; the low-limit test wins
  assign ul_x = ADD_W'(ul_r);
  assign hi_x = ADD_W'(hi_r);
  assign lo_x = ADD_W'(lo_r);
  always_comb begin
    tmp_nxt = '0;
    if (ul_x > hi_x) begin
      tmp_nxt = sat_add(hi_x, -ul_x);
    end
    if (ul_x < lo_x) begin
      tmp_nxt = sat_add(lo_x, -ul_x);
    end
  end

  always_comb begin
    case (ctl.acc_op)
      AO_HOLD:      acc_nxt = acc_r;
      AO_LOAD_Q:    acc_nxt = q;
      AO_ADD_Q:     acc_nxt = sat_add(ADD_W'(acc_r), ADD_W'(q));
      AO_ADD_INTEG: acc_nxt = sat_add(ADD_W'(acc_r), ADD_W'(phase_r ? ib_r : il_r));
      AO_ADD_ERR:   acc_nxt = sat_add(ADD_W'(acc_r), ADD_W'(e_r));
      default:      acc_nxt = acc_r;
    endcase
  end

  // clamp: high test first, then low
  always_comb begin
    drive_nxt = ERR_W'(acc_r);
    hit_nxt   = HIT_NONE;
    if (ADD_W'(acc_r) > hi_x) begin
      drive_nxt = hi_r;
      hit_nxt   = HIT_HIGH;
      if (hi_x < lo_x) begin
        drive_nxt = lo_r;
        hit_nxt   = HIT_LOW;
      end
    end else if (ADD_W'(acc_r) < lo_x) begin
      drive_nxt = lo_r;
      hit_nxt   = HIT_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      e_r <= in_error_in;
    end
    if (ctl.tmp_en) begin
      tmp_r <= tmp_nxt;
    end
    if (ctl.mul_en) begin
      prod_r <= P_W'(mul_a) * P_W'(mul_g);
    end
    acc_r <= acc_nxt;
    if (ctl.integ_en) begin
      integ_r <= acc_r;
    end
    if (ctl.commit) begin
      out_drive_r <= drive_nxt;
      out_hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      el_r        <= '0;
      eb_r        <= '0;
      il_r        <= '0;
      ib_r        <= '0;
      ul_r        <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        eb_r    <= el_r;
        el_r    <= e_r;
        ib_r    <= il_r;
        il_r    <= integ_r;
        ul_r    <= acc_r;
        phase_r <= ~phase_r;
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_busy      = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_limit_hit = out_hit_r;

endmodule

`default_nettype wire

// ===== sv/pst_checker.sv =====
// ----------------------------------------------------------------------------
// pst_checker - port-level checks for the PID controller
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_checker
  import pst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [ERR_W-1:0] out_drive,
  input wire logic [1:0]       out_limit_hit
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a taken sample is followed by a stalled input
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transaction");

  // held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drive)
                                  && $stable(out_limit_hit)))
    else $error("stalled result changed");

  // result only on a valid code
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_limit_hit == HIT_NONE || out_limit_hit == HIT_HIGH
                   || out_limit_hit == HIT_LOW))
    else $error("bad limit_hit code");

  // a new result is loaded only from the busy part of the program
  a_load_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && $past(rst_n)) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

endmodule

bind pid_simpson_trapezoid_antiwindup_top pst_checker u_pst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_drive     (out_drive),
  .out_limit_hit (out_limit_hit)
);

`default_nettype wire
